// ===== sv/ascii_hex_bcc_frame_checker_unit_macros.svh =====
// assertion macros for the ascii hex bcc frame checker
// included by hexbcc_core, the module that carries concurrent assertions
`ifndef ASCII_HEX_BCC_FRAME_CHECKER_UNIT_MACROS_SVH
`define ASCII_HEX_BCC_FRAME_CHECKER_UNIT_MACROS_SVH

// same-cycle implication
`define HEXBCC_ASSERT_SAME(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("hexbcc assertion failed");

// next-cycle implication
`define HEXBCC_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("hexbcc assertion failed");

`endif

// ===== sv/hexbcc_pkg.sv =====
// shared types, constants, the hex digit decode and the character reject check for the frame checker
// no dependencies
`timescale 1ns / 1ps

package hexbcc_pkg;

   localparam int unsigned IDX_W = 12;

   localparam logic [IDX_W-1:0] MAX_INDEX_RESET = 12'd1000;

   localparam logic [7:0] ETX_BYTE = 8'h03;

   localparam logic [1:0] PH_IDLE = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_HIGH = 2'd2;
   localparam logic [1:0] PH_LOW  = 2'd3;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_CHAR = 2'd1;
   localparam logic [1:0] ST_TOO_LONG = 2'd2;
   localparam logic [1:0] ST_MISMATCH = 2'd3;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       frame_start;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] computed_bcc;
      logic [7:0] received_bcc;
   } rsp_type;

   function automatic logic [7:0] hex_digit(input logic [7:0] c);
      logic [7:0] d;
      d = c - 8'h30;
      if (d > 8'h10) begin
         d = d - 8'd7;
      end
      return d;
   endfunction

   function automatic logic is_rejected(input logic [7:0] b);
      return (b > 8'h46) || ((b > 8'h39) && (b < 8'h41));
   endfunction

endpackage

// ===== sv/ascii_hex_bcc_frame_checker_unit.sv =====
// path: req transaction reaches rsp_valid through the input register, then the result register
// throughput: one transaction per cycle while rsp_ready is high; a status per frame
// a waiting result blocks only the input register, which still takes one more transaction
// reset: synchronous, active high; clears frame state, both valid flags, max_index to 1000
// depends on hexbcc_pkg and hexbcc_core
`timescale 1ns / 1ps

module ascii_hex_bcc_frame_checker_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  hexbcc_pkg::req_type           req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output hexbcc_pkg::rsp_type           rsp_data,
   input  logic                          csr_wr_en,
   input  logic [hexbcc_pkg::IDX_W-1:0]  csr_wr_data
);
   import hexbcc_pkg::*;

   logic [IDX_W-1:0] max_index_ff;
   logic             in_valid_ff, in_valid_in;
   req_type          in_item_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff;
   logic             out_free;
   logic             in_fire;
   logic             core_res_valid;
   rsp_type          core_res;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign in_fire     = in_valid_ff && out_free;
   assign req_ready   = !in_valid_ff || in_fire;
   assign in_valid_in = (req_valid && req_ready) || (in_valid_ff && !in_fire);
   assign rsp_valid_in = core_res_valid || (rsp_valid_ff && !rsp_ready);

   hexbcc_core u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (in_fire),
      .item      (in_item_ff),
      .max_index (max_index_ff),
      .res_valid (core_res_valid),
      .res       (core_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         max_index_ff <= MAX_INDEX_RESET;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            max_index_ff <= csr_wr_data;
         end
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (core_res_valid) begin
         rsp_data_ff <= core_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/hexbcc_core.sv =====
// frame state, running sum and status decision for one transaction per cycle while item_fire is high
// depends on hexbcc_pkg and the assertion macro header
`timescale 1ns / 1ps
`include "ascii_hex_bcc_frame_checker_unit_macros.svh"

module hexbcc_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   item_fire,
   input  hexbcc_pkg::req_type                    item,
   input  logic [hexbcc_pkg::IDX_W-1:0]           max_index,
   output logic                                   res_valid,
   output hexbcc_pkg::rsp_type                    res
);
   import hexbcc_pkg::*;

   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       sum_ff, sum_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [7:0]       high_ff, high_in;
   logic [7:0]       sum_add;
   logic [7:0]       hi_digit;
   logic [7:0]       lo_digit;
   logic [7:0]       rx_value;
   logic             body_late;

   assign sum_add   = sum_ff + item.data_byte;
   assign hi_digit  = hex_digit(high_ff);
   assign lo_digit  = hex_digit(item.data_byte);
   assign rx_value  = {hi_digit[3:0], 4'h0} | lo_digit;
   assign body_late = (idx_ff > {{(IDX_W-1){1'b0}}, 1'b1});

   always_comb begin
      phase_in  = phase_ff;
      sum_in    = sum_ff;
      idx_in    = idx_ff;
      high_in   = high_ff;
      res_valid = 1'b0;
      res       = '0;
      if (item_fire) begin
         if (item.frame_start) begin
            phase_in = PH_BODY;
            sum_in   = '0;
            idx_in   = {{(IDX_W-1){1'b0}}, 1'b1};
            high_in  = '0;
         end else begin
            unique case (phase_ff)
               PH_BODY: begin
                  sum_in = sum_add;
                  res.computed_bcc = sum_add;
                  priority if (body_late && item.data_byte == ETX_BYTE) begin
                     phase_in = PH_HIGH;
                  end else if (body_late && is_rejected(item.data_byte)) begin
                     res_valid  = 1'b1;
                     res.status = ST_BAD_CHAR;
                     phase_in   = PH_IDLE;
                  end else if (idx_ff >= max_index) begin
                     res_valid  = 1'b1;
                     res.status = ST_TOO_LONG;
                     phase_in   = PH_IDLE;
                  end else begin
                     idx_in = idx_ff + 1'b1;
                  end
               end
               PH_HIGH: begin
                  high_in  = item.data_byte;
                  phase_in = PH_LOW;
               end
               PH_LOW: begin
                  res_valid        = 1'b1;
                  res.computed_bcc = sum_ff;
                  res.received_bcc = rx_value;
                  res.status       = (rx_value == sum_ff) ? ST_OK : ST_MISMATCH;
                  phase_in         = PH_IDLE;
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sum_ff   <= '0;
         idx_ff   <= '0;
         high_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         sum_ff   <= sum_in;
         idx_ff   <= idx_in;
         high_ff  <= high_in;
      end
   end

   `HEXBCC_ASSERT_SAME(a_res_needs_frame, clock, reset, res_valid, (phase_ff != PH_IDLE) && !item.frame_start)
   `HEXBCC_ASSERT_NEXT(a_idle_after_res, clock, reset, res_valid, phase_ff == PH_IDLE)
   `HEXBCC_ASSERT_SAME(a_ok_means_match, clock, reset, res_valid && res.status == ST_OK, res.received_bcc == res.computed_bcc)
   `HEXBCC_ASSERT_SAME(a_early_end_no_rx, clock, reset, res_valid && (res.status == ST_BAD_CHAR || res.status == ST_TOO_LONG), res.received_bcc == 8'h00)
   `HEXBCC_ASSERT_NEXT(a_start_restarts, clock, reset, item_fire && item.frame_start, phase_ff == PH_BODY && sum_ff == 8'h00)

endmodule
